### rtl/pepm_pkg.sv
// Shared types and constants for the pulse energy and power meter.
// Used by pepm_div, pulse_energy_power_meter_top and pepm_check.
`default_nettype none

package pepm_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int TIME_WIDTH  = 32;
	localparam int DATA_W      = 32;
	localparam int DVD_W       = (COUNT_WIDTH > DATA_W) ? COUNT_WIDTH : DATA_W;
	localparam int DVS_W       = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
	localparam int DIV_CNT_W   = $clog2(DVD_W);

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int OP_W        = 3;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_FIELD_W = 3 * DATA_W + 1;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	localparam logic [31:0] NUMERATOR_RST  = 32'd10000000;
	localparam logic [15:0] DIVISOR_RST    = 16'd360;
	localparam logic [7:0]  MIN_PULSES_RST = 8'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POWER_NUMERATOR = 2'd0,
		REG_ENERGY_DIVISOR  = 2'd1,
		REG_MIN_PULSES      = 2'd2
	} cfg_reg_t;

	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 3'd0,
		OP_PULSE   = 3'd1,
		OP_UPDATE  = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_RESTORE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_FIN
	} div_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_PDIV_GO,
		ST_PDIV_WAIT,
		ST_EDIV_GO,
		ST_EDIV_WAIT,
		ST_OUT
	} mtr_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

### rtl/pepm_div.sv
// Shared restoring divider, one quotient bit per cycle, rounds to nearest (halves up).
// Result saturates at DATA_W bits. Depends on pepm_pkg.
`default_nettype none

module pepm_div
	import pepm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DVD_W-1:0]  dividend,
	input  wire logic [DVS_W-1:0]  divisor,
	output div_stat_t              stat,
	output logic      [DATA_W-1:0] result
);

	div_state_t            state_q;
	div_state_t            state_nx;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DVD_W-1:0]      quo_q;
	logic [DVS_W-1:0]      rem_q;
	logic [DVS_W-1:0]      dvs_q;

	logic [DVS_W:0]        rem_sh;
	logic                  ge;
	logic [DVS_W:0]        rem_nx;
	logic [DVS_W-1:0]      half_gap;
	logic                  round_up;
	logic [DVD_W:0]        sum;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	assign half_gap = dvs_q - rem_q;
	assign round_up = rem_q >= half_gap;
	assign sum      = {1'b0, quo_q} + (DVD_W + 1)'(round_up);

	always_comb begin
		if (sum > (DVD_W + 1)'({DATA_W{1'b1}})) begin
			result = {DATA_W{1'b1}};
		end else begin
			result = sum[DATA_W-1:0];
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			DIV_IDLE: begin
				if (start) state_nx = DIV_RUN;
			end
			DIV_RUN: begin
				if (cnt_q == DIV_CNT_W'(DVD_W - 1)) state_nx = DIV_FIN;
			end
			DIV_FIN: state_nx = DIV_IDLE;
			default: state_nx = DIV_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q != DIV_IDLE);
		stat.done = (state_q == DIV_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == DIV_RUN) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (state_q == DIV_RUN) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= rem_nx[DVS_W-1:0];
		end
	end

endmodule

`default_nettype wire

### rtl/pulse_energy_power_meter_top.sv
// Pulse energy and power meter, top level: item sequencer, state and config registers.
// Depends on pepm_pkg and pepm_div.
//
// Input channel s_*: one item per transfer, s_tuser carries the op code
// (tick, pulse, update, clear, restore), s_tdata the restore value.
// Output channel m_*: one result per input item, showing the state after it.
// Config port: cfg_we writes cfg_wdata to register cfg_index (0 numerator,
// 1 energy divisor, 2 minimum pulses); other indexes are dropped.
// Each item runs through one shared bit-serial divider: the energy division
// always, the power division on an update that qualifies. An item passes
// ST_APPLY, the power division if any, the energy division and ST_OUT, which
// loads the output register; the next item is then taken back in ST_IDLE.
// s_tready is high only while no item is in work. A finished result waits
// in the output register; when the receiver stalls with one result pending,
// the next item is still worked up to its result and then waits for space.
// Reset clears all counts, power and timestamp and loads the config defaults.
`default_nettype none

module pulse_energy_power_meter_top
	import pepm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // [31:0] restore_value
	input  wire logic [OP_W-1:0]        s_tuser,  // [2:0] op
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [31:0] power_value, [63:32] energy_value, [95:64] pulse_total,
	// [96] power_saturated, [103:97] zero
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	mtr_state_t              state_q;
	mtr_state_t              state_nx;

	logic [31:0]             numerator_q;
	logic [15:0]             divisor_q;
	logic [7:0]              min_pulses_q;

	logic [TIME_WIDTH-1:0]   timestamp_q;
	logic [TIME_WIDTH-1:0]   last_pulse_q;
	logic [TIME_WIDTH-1:0]   period_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	logic [COUNT_WIDTH-1:0]  cau_q;
	logic [DATA_W-1:0]       power_q;
	logic                    sat_q;
	logic [DATA_W-1:0]       energy_q;
	logic [OP_W-1:0]         op_q;
	logic [IN_TDATA_W-1:0]   restore_q;

	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;

	logic [COUNT_WIDTH-1:0]  since;
	logic                    enough;
	logic                    need_pdiv;
	logic                    out_free;
	logic [DVD_W-1:0]        count_ext;

	logic                    div_start;
	logic [DVD_W-1:0]        div_dvd;
	logic [DVS_W-1:0]        div_dvs;
	div_stat_t               div_stat;
	logic [DATA_W-1:0]       div_result;

	pepm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.result   (div_result)
	);

	assign since     = count_q - cau_q;
	assign enough    = since > COUNT_WIDTH'(min_pulses_q);
	assign need_pdiv = (op_q == OP_UPDATE) && enough && (period_q != '0);
	assign out_free  = !m_tvalid_q || m_tready;
	assign count_ext = DVD_W'(count_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nx = ST_APPLY;
			end
			ST_APPLY: begin
				state_nx = need_pdiv ? ST_PDIV_GO : ST_EDIV_GO;
			end
			ST_PDIV_GO: state_nx = ST_PDIV_WAIT;
			ST_PDIV_WAIT: begin
				if (div_stat.done) state_nx = ST_EDIV_GO;
			end
			ST_EDIV_GO: state_nx = ST_EDIV_WAIT;
			ST_EDIV_WAIT: begin
				if (div_stat.done) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_PDIV_GO) || (state_q == ST_EDIV_GO);
		if (state_q == ST_PDIV_GO) begin
			div_dvd = DVD_W'(numerator_q);
			div_dvs = DVS_W'(period_q);
		end else begin
			div_dvd = count_ext;
			div_dvs = (divisor_q == 16'd0) ? DVS_W'(1) : DVS_W'(divisor_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q  <= NUMERATOR_RST;
			divisor_q    <= DIVISOR_RST;
			min_pulses_q <= MIN_PULSES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POWER_NUMERATOR: numerator_q  <= cfg_wdata[31:0];
				REG_ENERGY_DIVISOR:  divisor_q    <= cfg_wdata[15:0];
				REG_MIN_PULSES:      min_pulses_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q      <= s_tuser;
			restore_q <= s_tdata;
		end
		if (state_q == ST_EDIV_WAIT && div_stat.done) begin
			energy_q <= div_result;
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {(OUT_TDATA_W - OUT_FIELD_W)'(0), sat_q, count_ext[DATA_W-1:0],
				energy_q, power_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			timestamp_q  <= '0;
			last_pulse_q <= '0;
			period_q     <= '0;
			count_q      <= '0;
			cau_q        <= '0;
			power_q      <= '0;
			sat_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_APPLY) begin
				unique case (op_q)
					OP_TICK: timestamp_q <= timestamp_q + TIME_WIDTH'(1);
					OP_PULSE: begin
						period_q     <= timestamp_q - last_pulse_q;
						last_pulse_q <= timestamp_q;
						count_q      <= count_q + COUNT_WIDTH'(1);
					end
					OP_UPDATE: begin
						if (enough && period_q == '0) begin
							power_q <= {DATA_W{1'b1}};
							sat_q   <= 1'b1;
						end else if (!enough) begin
							power_q <= '0;
							sat_q   <= 1'b0;
						end
						cau_q <= count_q;
					end
					OP_CLEAR: begin
						count_q <= '0;
						cau_q   <= '0;
					end
					OP_RESTORE: count_q <= COUNT_WIDTH'(restore_q);
					default: ;
				endcase
			end
			if (state_q == ST_PDIV_WAIT && div_stat.done) begin
				power_q <= div_result;
				sat_q   <= 1'b0;
			end
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/pepm_check.sv
// Port-level checks for pulse_energy_power_meter_top, bound to every instance.
// Depends on pepm_pkg.
`default_nettype none

module pepm_check
	import pepm_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result shown the cycle after its transfer");

	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $rose(s_tready))
		else $error("result shown without ending the item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_sat_power: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3*DATA_W] |-> m_tdata[DATA_W-1:0] == {DATA_W{1'b1}})
		else $error("saturated flag without full-scale power");

endmodule

bind pulse_energy_power_meter_top pepm_check u_pepm_check (.*);

`default_nettype wire

### tb/pepm_check.sv
`timescale 1ns / 100ps
// Checker for the pulse energy and power meter: watches the config port and both
// stream channels, predicts each result and compares it field by field.
// Depends on pepm_pkg.

module pepm_scoreboard
	import pepm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [OP_W-1:0]        s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	output int                          fail_count,
	output int                          pending,
	output int                          results_seen
);

	typedef struct packed {
		logic        saturated;
		logic [31:0] total;
		logic [31:0] energy;
		logic [31:0] power;
	} reading_t;

	logic [31:0]            numerator;
	logic [15:0]            divisor;
	logic [7:0]             min_pulses;
	logic [TIME_WIDTH-1:0]  now_ticks;
	logic [TIME_WIDTH-1:0]  last_edge;
	logic [TIME_WIDTH-1:0]  period;
	logic [COUNT_WIDTH-1:0] count;
	logic [COUNT_WIDTH-1:0] count_at_calc;
	logic [31:0]            power;
	logic                   saturated;
	reading_t               expected_readings[$];
	reading_t               want;

	function automatic logic [63:0] div_nearest(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = n / d;
		r = n % d;
		if (r >= d - r)
			q = q + 1;
		return q;
	endfunction

	function automatic reading_t advance_meter(logic [OP_W-1:0] op, logic [31:0] value);
		logic [COUNT_WIDTH-1:0] since;
		logic [63:0]            quot;
		reading_t               r;
		case (op)
		OP_TICK: now_ticks = now_ticks + 1'b1;
		OP_PULSE: begin
			period = now_ticks - last_edge;
			last_edge = now_ticks;
			count = count + 1'b1;
		end
		OP_UPDATE: begin
			since = count - count_at_calc;
			if (since > min_pulses) begin
				if (period == '0) begin
					power = '1;
					saturated = 1'b1;
				end else begin
					quot = div_nearest(64'(numerator), 64'(period));
					power = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
					saturated = 1'b0;
				end
			end else begin
				power = '0;
				saturated = 1'b0;
			end
			count_at_calc = count;
		end
		OP_CLEAR: begin
			count = '0;
			count_at_calc = '0;
		end
		OP_RESTORE: count = COUNT_WIDTH'(value);
		default: ;
		endcase
		quot = div_nearest(64'(count), (divisor == '0) ? 64'd1 : 64'(divisor));
		r.energy = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
		r.power = power;
		r.total = count[31:0];
		r.saturated = saturated;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator = NUMERATOR_RST;
			divisor = DIVISOR_RST;
			min_pulses = MIN_PULSES_RST;
			now_ticks = '0;
			last_edge = '0;
			period = '0;
			count = '0;
			count_at_calc = '0;
			power = '0;
			saturated = 1'b0;
			expected_readings.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_readings.size() == 0) begin
					$error("result transfer with nothing expected: %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_readings.pop_front();
					check_field("power_value", want.power, m_tdata[31:0]);
					check_field("energy_value", want.energy, m_tdata[63:32]);
					check_field("pulse_total", want.total, m_tdata[95:64]);
					check_field("power_saturated", 32'(want.saturated), 32'(m_tdata[96]));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				REG_POWER_NUMERATOR: numerator = cfg_wdata;
				REG_ENERGY_DIVISOR: divisor = cfg_wdata[15:0];
				REG_MIN_PULSES: min_pulses = cfg_wdata[7:0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_readings.push_back(advance_meter(s_tuser, s_tdata));
			pending <= expected_readings.size();
		end
	end

endmodule

### tb/tb_pulse_energy_power_meter_top.sv
`timescale 1ns / 100ps
// Testbench top for the pulse energy and power meter: clock, reset, config writes,
// directed and random item stimulus with sender and receiver stalls, and the verdict.
// Depends on pepm_pkg, pulse_energy_power_meter_top and pepm_scoreboard.

module tb_pulse_energy_power_meter_top;
	import pepm_pkg::*;

	localparam logic [OP_W-1:0]      OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0]      OP_SPARE_LAST  = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED   = 2'd3;
	localparam int                   RANDOM_ITEMS   = 600;
	localparam int                   PHASES         = 6;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]        s_tuser = '0;
	logic                   m_tready = 1'b0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int results_seen;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int items_sent = 0;
	int settings_used = 1;

	pulse_energy_power_meter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	pepm_scoreboard u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_item(logic [OP_W-1:0] op, logic [31:0] value);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= value;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop valid, then hold until every expected result has been taken
	task automatic wait_all_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic run_traffic(int n_items);
		int          start;
		int          pick;
		logic [31:0] value;
		start = items_sent;
		while (items_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				repeat ($urandom_range(6, 1)) begin
					repeat ($urandom_range(4))
						send_item(OP_TICK, $urandom);
					send_item(OP_PULSE, $urandom);
				end
				send_item(OP_UPDATE, $urandom);
			end else if (pick < 76) begin
				send_item(OP_CLEAR, $urandom);
			end else if (pick < 86) begin
				case ($urandom_range(4))
				0: value = '0;
				1: value = '1;
				2: value = 32'hFFFF_FFFF - $urandom_range(8);
				3: value = $urandom_range(2000);
				default: value = $urandom;
				endcase
				send_item(OP_RESTORE, value);
			end else if (pick < 91) begin
				send_item(OP_W'(OP_SPARE_FIRST + $urandom_range(OP_SPARE_LAST - OP_SPARE_FIRST)),
					$urandom);
			end else if (pick < 96) begin
				send_item(OP_UPDATE, $urandom);
			end else begin
				send_item(OP_TICK, $urandom);
			end
			if ($urandom_range(39) == 0)
				wait_all_results();
		end
	endtask

	initial begin
		int phase;
		tx_idle_pct = 30;
		rx_idle_pct = 79;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// power at reset defaults, zero period saturation, periods from ticks
		send_item(OP_UPDATE, $urandom);
		send_item(OP_PULSE, $urandom);
		send_item(OP_PULSE, $urandom);
		send_item(OP_PULSE, $urandom);
		send_item(OP_UPDATE, $urandom);
		repeat (3) send_item(OP_TICK, $urandom);
		send_item(OP_PULSE, $urandom);
		send_item(OP_UPDATE, $urandom);
		send_item(OP_TICK, $urandom);
		send_item(OP_PULSE, $urandom);
		send_item(OP_TICK, $urandom);
		send_item(OP_PULSE, $urandom);
		send_item(OP_TICK, $urandom);
		send_item(OP_TICK, $urandom);
		send_item(OP_PULSE, $urandom);
		send_item(OP_UPDATE, $urandom);
		// energy half rounds up, count wrap, clear, spare codes
		send_item(OP_RESTORE, 32'd180);
		send_item(OP_RESTORE, 32'hFFFF_FFFF);
		send_item(OP_PULSE, $urandom);
		send_item(OP_UPDATE, $urandom);
		send_item(OP_RESTORE, 32'h5555_AAAA);
		send_item(OP_CLEAR, 32'hAAAA_5555);
		send_item(OP_SPARE_FIRST, 32'hAAAA_5555);
		send_item(OP_W'(OP_SPARE_FIRST + 1), 32'h0000_0000);
		send_item(OP_SPARE_LAST, 32'hFFFF_FFFF);
		wait_all_results();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: begin
				write_reg(REG_POWER_NUMERATOR, 32'hFFFF_FFFF);
				write_reg(REG_ENERGY_DIVISOR, 32'hFFFF_0001);
				write_reg(REG_MIN_PULSES, 32'hFFFF_FF00);
				write_reg(REG_UNMAPPED, $urandom);
			end
			1: begin
				write_reg(REG_POWER_NUMERATOR, 32'd1);
				write_reg(REG_ENERGY_DIVISOR, 32'hFFFF_FFFF);
				write_reg(REG_MIN_PULSES, 32'hFFFF_FFFF);
			end
			2: begin
				tx_idle_pct = 79;
				rx_idle_pct = 30;
				write_reg(REG_POWER_NUMERATOR, $urandom);
				write_reg(REG_ENERGY_DIVISOR, 32'd0);
				write_reg(REG_MIN_PULSES, $urandom_range(5));
			end
			3: begin
				write_reg(REG_POWER_NUMERATOR, $urandom_range(100000, 1));
				write_reg(REG_ENERGY_DIVISOR, $urandom_range(65535, 1));
				write_reg(REG_MIN_PULSES, $urandom_range(8));
			end
			4: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				write_reg(REG_POWER_NUMERATOR, NUMERATOR_RST);
				write_reg(REG_ENERGY_DIVISOR, DIVISOR_RST);
				write_reg(REG_MIN_PULSES, MIN_PULSES_RST);
			end
			default: begin
				write_reg(REG_POWER_NUMERATOR, $urandom);
				write_reg(REG_ENERGY_DIVISOR, $urandom_range(1000, 1));
				write_reg(REG_MIN_PULSES, $urandom_range(255));
			end
			endcase
			settings_used++;
			run_traffic(RANDOM_ITEMS / PHASES);
			wait_all_results();
		end

		repeat (80) @(posedge clk);
		$display("Sent %0d items, checked %0d results across %0d register settings,",
			items_sent, results_seen, settings_used);
		$display("with stalls biased to each side in turn and a stretch without any.");
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
